// ----- rtl/vlpd_pkg.sv -----
// Shared types and codes for the varint length-prefixed deframer.
`timescale 1ns / 1ps

package vlpd_pkg;

  localparam int LenW     = 35;
  localparam int DigitW   = 7;
  localparam int ContBit  = 7;
  localparam int ByteW    = 8;
  localparam int StatusW  = 2;
  localparam int CauseW   = 3;

  localparam logic [StatusW-1:0] StLen    = 2'd0;
  localparam logic [StatusW-1:0] StData   = 2'd1;
  localparam logic [StatusW-1:0] StClosed = 2'd2;

  localparam logic [CauseW-1:0] CauseNone       = 3'd0;
  localparam logic [CauseW-1:0] CauseZero       = 3'd1;
  localparam logic [CauseW-1:0] CauseOver       = 3'd2;
  localparam logic [CauseW-1:0] CauseTooLong    = 3'd3;
  localparam logic [CauseW-1:0] CauseDisconnect = 3'd4;

  localparam logic KindByte       = 1'b0;
  localparam logic KindDisconnect = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] in_byte;
  } vlpd_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [CauseW-1:0]  close_cause;
    logic [ByteW-1:0]   payload_byte;
    logic               last_of_packet;
    logic [LenW-1:0]    packet_length;
  } vlpd_result_t;

  typedef struct packed {
    logic              closed;
    logic [CauseW-1:0] reason;
  } vlpd_conn_t;

endpackage

// ----- rtl/vlpd_in_stage.sv -----
// Input register holding one accepted stream beat until the decoder takes it.
`timescale 1ns / 1ps

module vlpd_in_stage
  import vlpd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  vlpd_item_t item_i,
  input  logic       take_i,
  output logic       valid_o,
  output vlpd_item_t item_o
);

  logic       valid_q;
  logic       valid_d;
  vlpd_item_t item_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- rtl/vlpd_core.sv -----
// Framing state and the single-pass decode of one beat into one result.
`timescale 1ns / 1ps

module vlpd_core
  import vlpd_pkg::*;
#(
  parameter int MAX_LENGTH_BYTES = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  vlpd_item_t      item_i,
  input  logic [LenW-1:0] max_size_i,
  output vlpd_result_t    result_o,
  output vlpd_conn_t      conn_o
);

  localparam int PhW = $clog2(MAX_LENGTH_BYTES + 2);
  localparam logic [PhW-1:0] PhaseData = PhW'(MAX_LENGTH_BYTES + 1);
  localparam logic [PhW-1:0] PhaseLastLen = PhW'(MAX_LENGTH_BYTES - 1);
  localparam logic [PhW-1:0] PhaseLimit = PhW'(MAX_LENGTH_BYTES);

  logic [PhW-1:0]    phase_q, phase_d;
  logic [LenW-1:0]   acc_q, acc_d;
  logic [LenW-1:0]   cnt_q, cnt_d;
  logic              closed_q, closed_d;
  logic [CauseW-1:0] reason_q, reason_d;

  logic [LenW-1:0] digit_sh;
  logic [LenW-1:0] acc_new;
  logic [LenW-1:0] cnt_inc;
  logic            cnt_last;
  vlpd_result_t    res;

  // Place the seven payload bits of a length byte at the weight of its phase.
  always_comb begin
    digit_sh = '0;
    for (int i = 0; i < MAX_LENGTH_BYTES; i++) begin
      if (phase_q == PhW'(i)) begin
        digit_sh = LenW'(64'(item_i.in_byte[DigitW-1:0]) << (DigitW * i));
      end
    end
  end

  assign acc_new  = acc_q | digit_sh;
  assign cnt_inc  = cnt_q + LenW'(1);
  assign cnt_last = (cnt_inc == acc_q);

  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    closed_d = closed_q;
    reason_d = reason_q;

    res                = '0;
    res.status         = StClosed;
    res.close_cause    = reason_q;
    res.packet_length  = acc_q;

    if (closed_q) begin
      // A closed connection answers every beat and keeps its first cause.
    end else if (item_i.kind == KindDisconnect) begin
      closed_d        = 1'b1;
      reason_d        = CauseDisconnect;
      res.close_cause = CauseDisconnect;
    end else if (phase_q == PhaseData) begin
      res.status         = StData;
      res.close_cause    = CauseNone;
      res.payload_byte   = item_i.in_byte;
      res.last_of_packet = cnt_last;
      if (cnt_last) begin
        phase_d = '0;
        acc_d   = '0;
        cnt_d   = '0;
      end else begin
        cnt_d = cnt_inc;
      end
    end else if (phase_q >= PhaseLimit) begin
      closed_d        = 1'b1;
      reason_d        = CauseTooLong;
      res.close_cause = CauseTooLong;
    end else begin
      acc_d             = acc_new;
      res.packet_length = acc_new;
      if (item_i.in_byte[ContBit]) begin
        if (phase_q >= PhaseLastLen) begin
          closed_d        = 1'b1;
          reason_d        = CauseTooLong;
          res.close_cause = CauseTooLong;
        end else begin
          phase_d         = phase_q + PhW'(1);
          res.status      = StLen;
          res.close_cause = CauseNone;
        end
      end else if (acc_new == '0) begin
        closed_d        = 1'b1;
        reason_d        = CauseZero;
        res.close_cause = CauseZero;
      end else if ((max_size_i != '0) && (acc_new > max_size_i)) begin
        closed_d        = 1'b1;
        reason_d        = CauseOver;
        res.close_cause = CauseOver;
      end else begin
        phase_d         = PhaseData;
        cnt_d           = '0;
        res.status      = StLen;
        res.close_cause = CauseNone;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      acc_q    <= '0;
      cnt_q    <= '0;
      closed_q <= 1'b0;
      reason_q <= CauseNone;
    end else if (advance_i) begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      closed_q <= closed_d;
      reason_q <= reason_d;
    end
  end

  assign result_o = res;
  assign conn_o   = '{closed: closed_q, reason: reason_q};

endmodule

// ----- rtl/vlpd_out_stage.sv -----
// Result register that holds a finished result until the sink takes it.
`timescale 1ns / 1ps

module vlpd_out_stage
  import vlpd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_valid_i,
  output logic         load_ready_o,
  input  vlpd_result_t result_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output vlpd_result_t result_o
);

  logic         valid_q;
  vlpd_result_t result_q;

  assign load_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_ready_o) begin
      valid_q <= load_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_valid_i && load_ready_o) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

// ----- rtl/varint_length_prefixed_deframer.sv -----
// Top level of the varint length-prefixed packet deframer.
//
//   channel   direction  handshake              payload
//   in        sink       in_valid_i/in_ready_o   kind_i, in_byte_i
//   out       source     out_valid_o/out_ready_i status_o, close_cause_o, payload_byte_o,
//                                                last_of_packet_o, packet_length_o
//   cfg       sink       cfg_valid_i/cfg_ready_o max_packet_size_i
//
// One beat in gives one result beat out, and a beat is taken every cycle while
// the output is not stalled. A beat is held in the input register and is then
// decoded into the result register, from which its result is offered.
// The decode step (one 35-bit add, compare and OR) sets the cycle time.
// Reset clears the framing state to the first length byte, open, no limit.
// A stalled output holds its result; the input register keeps taking beats
// until both registers are full.
`timescale 1ns / 1ps

module varint_length_prefixed_deframer
  import vlpd_pkg::*;
#(
  parameter int MAX_LENGTH_BYTES = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                kind_i,
  input  logic [ByteW-1:0]    in_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [StatusW-1:0]  status_o,
  output logic [CauseW-1:0]   close_cause_o,
  output logic [ByteW-1:0]    payload_byte_o,
  output logic                last_of_packet_o,
  output logic [LenW-1:0]     packet_length_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [LenW-1:0]     max_packet_size_i
);

  logic [LenW-1:0] max_size_q;
  vlpd_item_t      in_item;
  vlpd_item_t      staged_item;
  logic            staged_valid;
  logic            load_ready;
  logic            advance;
  vlpd_result_t    step_result;
  vlpd_result_t    out_result;
  vlpd_conn_t      conn;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_size_q <= max_packet_size_i;
    end
  end

  assign in_item = '{kind: kind_i, in_byte: in_byte_i};
  assign advance = staged_valid && load_ready;

  vlpd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .take_i     (advance),
    .valid_o    (staged_valid),
    .item_o     (staged_item)
  );

  vlpd_core #(
    .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .item_i     (staged_item),
    .max_size_i (max_size_q),
    .result_o   (step_result),
    .conn_o     (conn)
  );

  vlpd_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (staged_valid),
    .load_ready_o (load_ready),
    .result_i     (step_result),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (out_result)
  );

  assign status_o         = out_result.status;
  assign close_cause_o    = out_result.close_cause;
  assign payload_byte_o   = out_result.payload_byte;
  assign last_of_packet_o = out_result.last_of_packet;
  assign packet_length_o  = out_result.packet_length;

  // Once closed, the connection never reopens and its cause never changes.
  a_closed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conn.closed |=> conn.closed && $stable(conn.reason))
    else $error("closed connection reopened or changed cause");

  // A closed result always names a cause; other results never do.
  a_cause_on_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o == StClosed) == (close_cause_o != CauseNone)))
    else $error("close cause does not match status");

  // Only payload results carry a byte or an end-of-packet mark.
  a_payload_only_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != StData) |-> !last_of_packet_o && (payload_byte_o == '0))
    else $error("payload fields set on a non-payload result");

  // A closed connection decodes every staged beat into a closed result.
  a_closed_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conn.closed && advance |=> out_valid_o && (status_o == StClosed))
    else $error("beat after close not reported as closed");

endmodule
